@@ src/fpa_pkg.sv @@
`default_nettype none

package fpa_pkg;

	// fraction bits of the fixed-point word
	localparam int FRACTION_BITS = 14;
	// width of the divider quotient: a fixed dividend spans 32 + fraction bits
	localparam int DIV_W = 32 + FRACTION_BITS;

	// operation codes
	typedef enum logic [3:0] {
		K_I2F       = 4'd0,
		K_F2I_TRUNC = 4'd1,
		K_F2I_NEAR  = 4'd2,
		K_ADD_FF    = 4'd3,
		K_ADD_FI    = 4'd4,
		K_SUB_FF    = 4'd5,
		K_SUB_FI    = 4'd6,
		K_MUL_FF    = 4'd7,
		K_MUL_FI    = 4'd8,
		K_DIV_FF    = 4'd9,
		K_DIV_FI    = 4'd10,
		K_CLAMP     = 4'd11,
		K_LERP      = 4'd12
	} kind_t;

	// side data that travels with a request through the divider
	typedef struct packed {
		logic        use_div;
		logic        neg;
		logic        dz;
		logic [31:0] res;
	} div_tag_t;

	// fixed to integer, truncating or rounding half away from zero
	function automatic logic signed [32:0] f2i(input logic signed [31:0] a,
			input logic nearest);
		logic [32:0] mag;
		logic [32:0] q;
		mag = a[31] ? (33'd0 - {a[31], a}) : {1'b0, a};
		if (nearest) begin
			mag = mag + (33'd1 << (FRACTION_BITS - 1));
		end
		q = mag >> FRACTION_BITS;
		return a[31] ? $signed(33'd0 - q) : $signed(q);
	endfunction

endpackage

`default_nettype wire

@@ src/fixed_point_17_14_alu.sv @@
`default_nettype none

// channel | signals                                           | direction
// request | in_valid, in_ready, kind, operand_a..d, clamp_nearest | in
// result  | out_valid, out_ready, result, divide_by_zero      | out
//
// one request per cycle while the result side is not stalled; every request
// passes through the bit-per-stage divider
// reset clears only the valid bits; no clearing pass
// a stall on the result side freezes the whole pipeline, nothing is lost

module fixed_point_17_14_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [3:0]         kind,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	input  wire logic signed [31:0] operand_c,
	input  wire logic signed [31:0] operand_d,
	input  wire logic               clamp_nearest,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result,
	output logic                    divide_by_zero
);

	localparam int F = fpa_pkg::FRACTION_BITS;
	localparam int W = fpa_pkg::DIV_W;

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: registered request
	logic               v_s1, near_s1;
	logic [3:0]         kind_s1;
	logic signed [31:0] a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			c_s1    <= operand_c;
			d_s1    <= operand_d;
			near_s1 <= clamp_nearest;
		end
	end

	// simple operations and conversions
	logic [31:0]        bfix, simple_res;
	logic signed [32:0] conv, conv_t, conv_n;
	assign bfix   = 32'(b_s1) << F;
	assign conv_t = fpa_pkg::f2i(a_s1, 1'b0);
	assign conv_n = fpa_pkg::f2i(a_s1, 1'b1);
	assign conv   = near_s1 ? conv_n : conv_t;

	always_comb begin
		case (fpa_pkg::kind_t'(kind_s1))
			fpa_pkg::K_I2F:       simple_res = bfix;
			fpa_pkg::K_F2I_TRUNC: simple_res = conv_t[31:0];
			fpa_pkg::K_F2I_NEAR:  simple_res = conv_n[31:0];
			fpa_pkg::K_ADD_FF:    simple_res = a_s1 + b_s1;
			fpa_pkg::K_ADD_FI:    simple_res = a_s1 + bfix;
			fpa_pkg::K_SUB_FF:    simple_res = a_s1 - b_s1;
			fpa_pkg::K_SUB_FI:    simple_res = a_s1 - bfix;
			default:              simple_res = 32'd0;
		endcase
	end

	// stage 2
	logic               v_s2;
	logic [3:0]         kind_s2;
	logic signed [31:0] a_s2, b_s2, c_s2, d_s2, diff_s2;
	logic signed [32:0] conv_s2;
	logic [31:0]        res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			d_s2    <= d_s1;
			diff_s2 <= d_s1 - c_s1;
			conv_s2 <= conv;
			res_s2  <= simple_res;
		end
	end

	// products and clamp
	logic signed [63:0] prod_ab, prod_1, prod_2;
	logic signed [32:0] clamped;
	logic [31:0]        res2;
	assign prod_ab = 64'(a_s2) * 64'(b_s2);
	assign prod_1  = 64'(a_s2) * 64'(diff_s2);
	assign prod_2  = 64'(b_s2) * 64'(c_s2);

	always_comb begin
		if (conv_s2 < 33'(b_s2)) begin
			clamped = 33'(b_s2);
		end else if (conv_s2 > 33'(c_s2)) begin
			clamped = 33'(c_s2);
		end else begin
			clamped = conv_s2;
		end
		res2 = (fpa_pkg::kind_t'(kind_s2) == fpa_pkg::K_CLAMP) ? clamped[31:0] : res_s2;
	end

	// stage 3
	logic               v_s3;
	logic [3:0]         kind_s3;
	logic signed [31:0] a_s3, b_s3, d_s3;
	logic signed [63:0] pab_s3;
	logic [31:0]        p1_s3, p2_s3, res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			d_s3    <= d_s2;
			pab_s3  <= prod_ab;
			p1_s3   <= prod_1[31:0];
			p2_s3   <= prod_2[31:0];
			res_s3  <= res2;
		end
	end

	// product scaling, lerp sum and divider operands
	logic [63:0]        pab_sh;
	logic               corr;
	logic [31:0]        sum, res3;
	logic signed [W:0]  dvd;
	logic signed [31:0] dvs;
	logic               use_div;
	logic [W:0]         dvd_mag;
	fpa_pkg::div_tag_t  tag;

	assign pab_sh = 64'(pab_s3 >>> F);
	assign corr   = pab_s3[63] && (pab_s3[F-1:0] != '0);
	assign sum    = p1_s3 + p2_s3;

	always_comb begin
		use_div = 1'b0;
		dvd     = (W+1)'(a_s3);
		dvs     = b_s3;
		res3    = res_s3;
		case (fpa_pkg::kind_t'(kind_s3))
			fpa_pkg::K_MUL_FF: res3 = pab_sh[31:0] + 32'(corr);
			fpa_pkg::K_MUL_FI: res3 = pab_s3[31:0];
			fpa_pkg::K_DIV_FF: begin
				use_div = 1'b1;
				dvd     = (W+1)'(a_s3) <<< F;
			end
			fpa_pkg::K_DIV_FI: use_div = 1'b1;
			fpa_pkg::K_LERP: begin
				use_div = 1'b1;
				dvd     = (W+1)'($signed(sum));
				dvs     = d_s3;
			end
			default: ;
		endcase
		dvd_mag     = dvd[W] ? ((W+1)'(0) - dvd) : dvd;
		tag.use_div = use_div;
		tag.neg     = dvd[W] ^ dvs[31];
		tag.dz      = use_div && (dvs == 32'sd0);
		tag.res     = res3;
	end

	logic [31:0] dvs_mag;
	assign dvs_mag = dvs[31] ? (32'd0 - dvs) : dvs;

	logic              dv_valid;
	logic [31:0]       dv_quo;
	fpa_pkg::div_tag_t dv_tag;

	fpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.in_num    (dvd_mag[W-1:0]),
		.in_den    (dvs_mag),
		.in_tag    (tag),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_tag   (dv_tag)
	);

	// output register: sign fix and selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			divide_by_zero <= dv_tag.dz;
			if (!dv_tag.use_div) begin
				result <= dv_tag.res;
			end else if (dv_tag.dz) begin
				result <= 32'sd0;
			end else begin
				result <= dv_tag.neg ? (32'd0 - dv_quo) : dv_quo;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/fpa_div.sv @@
`default_nettype none

// pipelined unsigned divider, one quotient bit per stage
module fpa_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_valid,
	input  wire logic [fpa_pkg::DIV_W-1:0]  in_num,
	input  wire logic [31:0]                in_den,
	input  wire fpa_pkg::div_tag_t          in_tag,
	output logic                            out_valid,
	output logic [31:0]                     out_quo,
	output fpa_pkg::div_tag_t               out_tag
);

	localparam int W = fpa_pkg::DIV_W;

	logic [W-1:0]      num_s [0:W];
	logic [32:0]       rem_s [0:W];
	logic [31:0]       den_s [0:W];
	fpa_pkg::div_tag_t tag_s [0:W];
	logic              vld_s [0:W];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s[0] <= in_num;
			rem_s[0] <= 33'd0;
			den_s[0] <= in_den;
			tag_s[0] <= in_tag;
		end
	end

	// restoring steps
	for (genvar k = 0; k < W; k++) begin : g_step
		logic [32:0] rsh;
		logic        ge;
		assign rsh = {rem_s[k][31:0], num_s[k][W-1]};
		assign ge  = rsh >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? (rsh - {1'b0, den_s[k]}) : rsh;
				num_s[k+1] <= {num_s[k][W-2:0], ge};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign out_quo   = num_s[W][31:0];
	assign out_tag   = tag_s[W];

endmodule

`default_nettype wire
